[hw/rtl/nat_pkg.sv]
// shared types, constants and character helpers for the network address text parser
// no dependencies; used by nat_if, nat_parser, nat_out_stage and the top level
`timescale 1ns / 1ps

package nat_pkg;

  // address format register codes
  localparam logic FMT_IPV4 = 1'b0;
  localparam logic FMT_MAC  = 1'b1;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned ACC_W  = 9;
  localparam int unsigned IDX_W  = 3;

  // characters of interest
  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_COLON  = 8'h3A;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_X_LO   = 8'h78;
  localparam logic [7:0] CHAR_X_UP   = 8'h58;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;

  // last field index per format
  localparam logic [IDX_W-1:0] LAST_IPV4 = 3'd3;
  localparam logic [IDX_W-1:0] LAST_MAC  = 3'd5;

  // accumulator limits
  localparam logic [ACC_W-1:0] BYTE_MAX = 9'd255;
  localparam logic [ACC_W-1:0] ACC_SAT  = 9'd256;

  // digit code for a character that is no digit
  localparam logic [4:0] DIGIT_NONE = 5'd16;

  // phase within one field
  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SPACE  = 3'd1,
    PH_SIGN   = 3'd2,
    PH_ZERO   = 3'd3,
    PH_PREFIX = 3'd4,
    PH_DIGITS = 3'd5
  } phase_e;

  // one result transaction
  typedef struct packed {
    logic              parse_error;
    logic [ADDR_W-1:0] address_value;
  } result_t;

  // whitespace as in isspace, nul excluded
  function automatic logic is_space(input logic [7:0] c);
    logic res;
    res = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    return res;
  endfunction

  // digit value in the current base, DIGIT_NONE otherwise
  function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hex);
    logic [4:0] res;
    res = DIGIT_NONE;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      res = 5'(c - 8'h30);
    end else if (hex && (c >= 8'h61) && (c <= 8'h66)) begin
      res = 5'(c - 8'h57);
    end else if (hex && (c >= 8'h41) && (c <= 8'h46)) begin
      res = 5'(c - 8'h37);
    end
    return res;
  endfunction

endpackage

[hw/rtl/nat_if.sv]
// channel interfaces: character input and result output, valid/ready handshake
// depends on nat_pkg for the address width
`timescale 1ns / 1ps

interface nat_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;

  modport source (output valid, output text_char, input ready);
  modport sink   (input valid, input text_char, output ready);
endinterface

interface nat_result_if;
  logic                          valid;
  logic                          ready;
  logic                          parse_error;
  logic [nat_pkg::ADDR_W-1:0]    address_value;

  modport source (output valid, output parse_error, output address_value, input ready);
  modport sink   (input valid, input parse_error, input address_value, output ready);
endinterface

[hw/rtl/nat_in_stage.sv]
// input register: captures one character transaction per cycle unless the held character is not taken
// depends on nat_char_if
`timescale 1ns / 1ps

module nat_in_stage (
  input  logic         clk_i,
  input  logic         rst_ni,
  nat_char_if.sink     char_i,
  input  logic         take_i,
  output logic         valid_o,
  output logic [7:0]   char_o
);

  logic       valid_q, valid_d;
  logic [7:0] char_q;

  // register is free when empty or drained this cycle
  assign char_i.ready = !valid_q || take_i;
  assign valid_d      = char_i.valid || (valid_q && !take_i);

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // character payload
  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      char_q <= char_i.text_char;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;

endmodule

[hw/rtl/nat_parser.sv]
// field parser: per-character state update and result build on the nul terminator
// depends on nat_pkg
`timescale 1ns / 1ps

module nat_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fmt_i,
  input  logic               valid_i,
  input  logic [7:0]         char_i,
  input  logic               out_free_i,
  output logic               take_o,
  output logic               res_valid_o,
  output nat_pkg::result_t   res_o
);

  nat_pkg::phase_e                  phase_q, phase_d;
  logic [nat_pkg::IDX_W-1:0]        idx_q, idx_d;
  logic [nat_pkg::ACC_W-1:0]        acc_q, acc_d;
  logic                             minus_q, minus_d;
  logic                             err_q, err_d;
  logic [nat_pkg::ADDR_W-1:0]       shift_q, shift_d;

  logic                             hex;
  logic                             term;
  logic [4:0]                       dig;
  logic                             is_dig;
  logic                             is_sign;
  logic                             is_ws;
  logic [12:0]                      acc_mul;
  logic [12:0]                      acc_sum;
  logic [nat_pkg::ACC_W-1:0]        acc_step;
  logic [nat_pkg::IDX_W-1:0]        last_idx;
  logic [7:0]                       sep_char;
  logic                             ef_err;
  nat_pkg::phase_e                  dig_phase;

  // terminator waits only for a free result register
  assign term   = (char_i == nat_pkg::CHAR_NUL);
  assign take_o = valid_i && (!term || out_free_i);

  // character classification and accumulate step
  always_comb begin
    hex      = (fmt_i == nat_pkg::FMT_MAC);
    dig      = nat_pkg::digit_of(char_i, hex);
    is_dig   = (dig != nat_pkg::DIGIT_NONE);
    is_sign  = (char_i == nat_pkg::CHAR_PLUS) || (char_i == nat_pkg::CHAR_MINUS);
    is_ws    = !term && nat_pkg::is_space(char_i);
    acc_mul  = hex ? {acc_q, 4'b0000}
                   : (13'({acc_q, 3'b000}) + 13'({acc_q, 1'b0}));
    acc_sum  = acc_mul + 13'(dig);
    acc_step = (acc_sum > 13'(nat_pkg::BYTE_MAX)) ? nat_pkg::ACC_SAT
                                                  : acc_sum[nat_pkg::ACC_W-1:0];
    last_idx = hex ? nat_pkg::LAST_MAC : nat_pkg::LAST_IPV4;
    sep_char = hex ? nat_pkg::CHAR_COLON : nat_pkg::CHAR_DOT;
    dig_phase = (hex && (dig == 5'd0)) ? nat_pkg::PH_ZERO : nat_pkg::PH_DIGITS;
    // field end: range check then separator check
    ef_err   = (acc_q > nat_pkg::BYTE_MAX) || (minus_q && (acc_q != '0)) ||
               ((idx_q >= last_idx) ? !term : (char_i != sep_char));
  end

  // next state and result
  always_comb begin
    logic end_field;
    end_field = 1'b0;
    phase_d   = phase_q;
    idx_d     = idx_q;
    acc_d     = acc_q;
    minus_d   = minus_q;
    err_d     = err_q;
    shift_d   = shift_q;

    if (!err_q) begin
      case (phase_q)
        nat_pkg::PH_START: begin
          if (is_ws) begin
            phase_d = nat_pkg::PH_SPACE;
          end else if (is_sign) begin
            minus_d = (char_i == nat_pkg::CHAR_MINUS);
            phase_d = nat_pkg::PH_SIGN;
          end else if (is_dig) begin
            acc_d   = nat_pkg::ACC_W'(dig);
            phase_d = dig_phase;
          end else begin
            end_field = 1'b1;
          end
        end
        nat_pkg::PH_SPACE: begin
          if (is_ws) begin
            phase_d = phase_q;
          end else if (is_sign) begin
            minus_d = (char_i == nat_pkg::CHAR_MINUS);
            phase_d = nat_pkg::PH_SIGN;
          end else if (is_dig) begin
            acc_d   = nat_pkg::ACC_W'(dig);
            phase_d = dig_phase;
          end else begin
            err_d = 1'b1;
          end
        end
        nat_pkg::PH_SIGN: begin
          if (is_dig) begin
            acc_d   = nat_pkg::ACC_W'(dig);
            phase_d = dig_phase;
          end else begin
            err_d = 1'b1;
          end
        end
        nat_pkg::PH_ZERO: begin
          if ((char_i == nat_pkg::CHAR_X_LO) || (char_i == nat_pkg::CHAR_X_UP)) begin
            phase_d = nat_pkg::PH_PREFIX;
          end else if (is_dig) begin
            acc_d   = acc_step;
            phase_d = nat_pkg::PH_DIGITS;
          end else begin
            end_field = 1'b1;
          end
        end
        nat_pkg::PH_PREFIX: begin
          if (is_dig) begin
            acc_d   = acc_step;
            phase_d = nat_pkg::PH_DIGITS;
          end else begin
            err_d = 1'b1;
          end
        end
        nat_pkg::PH_DIGITS: begin
          if (is_dig) begin
            acc_d = acc_step;
          end else begin
            end_field = 1'b1;
          end
        end
        default: begin
          err_d = 1'b1;
        end
      endcase
    end

    // close the current field
    if (end_field) begin
      if (ef_err) begin
        err_d = 1'b1;
      end else begin
        shift_d = {shift_q[nat_pkg::ADDR_W-9:0], acc_q[7:0]};
        if (!term) begin
          idx_d   = idx_q + 3'd1;
          phase_d = nat_pkg::PH_START;
          acc_d   = '0;
          minus_d = 1'b0;
        end
      end
    end

    // result on the terminator
    res_valid_o         = take_o && term;
    res_o.parse_error   = err_d;
    res_o.address_value = err_d ? '0 : shift_d;

    // clear parse state after the terminator
    if (term) begin
      phase_d = nat_pkg::PH_START;
      idx_d   = '0;
      acc_d   = '0;
      minus_d = 1'b0;
      err_d   = 1'b0;
      shift_d = '0;
    end
  end

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nat_pkg::PH_START;
      idx_q   <= '0;
      acc_q   <= '0;
      minus_q <= 1'b0;
      err_q   <= 1'b0;
      shift_q <= '0;
    end else if (take_o) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      acc_q   <= acc_d;
      minus_q <= minus_d;
      err_q   <= err_d;
      shift_q <= shift_d;
    end
  end

endmodule

[hw/rtl/nat_out_stage.sv]
// result register: holds one result transaction until the sink takes it
// depends on nat_pkg and nat_result_if
`timescale 1ns / 1ps

module nat_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  nat_pkg::result_t   res_i,
  output logic               free_o,
  nat_result_if.source       result_o
);

  logic             valid_q, valid_d;
  nat_pkg::result_t res_q;

  // free when empty or being taken this cycle
  assign free_o  = !valid_q || result_o.ready;
  assign valid_d = load_i || (valid_q && !result_o.ready);

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign result_o.valid         = valid_q;
  assign result_o.parse_error   = res_q.parse_error;
  assign result_o.address_value = res_q.address_value;

endmodule

[hw/rtl/network_address_text_parser.sv]
// Network address text parser: IPv4 dotted decimal or MAC colon hex, one character a cycle unless stalled.
// Throughput: one character per cycle, except while a terminator stalls as described below.
// The result is registered: the terminating nul passes the input register and the parser, then the result register.
// A terminator stalls only while an earlier result still waits in the result register.
// Reset clears the parse state, empties both registers and selects IPv4 format.
// depends on nat_pkg, nat_if, nat_in_stage, nat_parser, nat_out_stage
`timescale 1ns / 1ps

module network_address_text_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  nat_char_if.sink       char_i,
  nat_result_if.source   result_o
);

  logic             fmt_q;
  logic             take;
  logic             ch_valid;
  logic [7:0]       ch;
  logic             out_free;
  logic             res_valid;
  nat_pkg::result_t res;

  // address format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= nat_pkg::FMT_IPV4;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  // character input register
  nat_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_i),
    .take_i  (take),
    .valid_o (ch_valid),
    .char_o  (ch)
  );

  // field parsing
  nat_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fmt_i       (fmt_q),
    .valid_i     (ch_valid),
    .char_i      (ch),
    .out_free_i  (out_free),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  nat_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (res_valid),
    .res_i    (res),
    .free_o   (out_free),
    .result_o (result_o)
  );

endmodule
